// ===== src/sfc_pkg.sv =====
// Shared types, constants and functions for the sensor frame checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sfc_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned WordW  = 16;
    localparam int unsigned IndexW = 3;

    localparam logic [WordW-1:0] CRC_START  = 16'hFFFF;
    localparam logic [WordW-1:0] CRC_POLY   = 16'hA001;
    localparam logic [WordW-1:0] SIGN_BIT   = 16'h8000;
    localparam logic [ByteW-1:0] CMD_READ   = 8'h03;
    localparam logic [ByteW-1:0] LEN_EXPECT = 8'h04;

    // Byte positions within a reply
    localparam logic [IndexW-1:0] IDX_CMD     = 3'd0;
    localparam logic [IndexW-1:0] IDX_LEN     = 3'd1;
    localparam logic [IndexW-1:0] IDX_HUM_HI  = 3'd2;
    localparam logic [IndexW-1:0] IDX_HUM_LO  = 3'd3;
    localparam logic [IndexW-1:0] IDX_TEMP_HI = 3'd4;
    localparam logic [IndexW-1:0] IDX_TEMP_LO = 3'd5;
    localparam logic [IndexW-1:0] IDX_CRC_LO  = 3'd6;
    localparam logic [IndexW-1:0] IDX_CRC_HI  = 3'd7;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_LEN = 2'd1,
        STATUS_BAD_CRC = 2'd2,
        STATUS_BAD_CMD = 2'd3
    } status_t;

    typedef struct packed {
        status_t           status;
        logic [WordW-1:0]  humidity_raw;
        logic [WordW-1:0]  temperature_raw;
        logic signed [WordW-1:0] temperature_tenths;
        logic              updated;
    } result_t;

    // Packed widths on the output stream
    localparam int unsigned ResultDataBits = 2 + 3 * WordW;
    localparam int unsigned ResultDataW    = ((ResultDataBits + 7) / 8) * 8;

    // Reflected CRC-16 update over one byte, one bit per step
    function automatic logic [WordW-1:0] crc_byte(input logic [WordW-1:0] crc_in,
                                                  input logic [ByteW-1:0] data);
        logic [WordW-1:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

    // Sign-magnitude word to two's complement tenths; negative zero gives zero
    function automatic logic signed [WordW-1:0] to_tenths(input logic [WordW-1:0] word);
        logic [WordW-1:0] mag;
        mag = word & ~SIGN_BIT;
        if ((word & SIGN_BIT) != '0)
            return $signed(-mag);
        return $signed(mag);
    endfunction

endpackage

// ===== src/sensor_frame_checker_core.sv =====
// Channel  Group            Payload
// in       s_axis_t*        tdata[7:0] rx_byte; tuser[0] frame_start
// out      m_axis_t*        tdata status, humidity_raw, temperature_raw,
//                           temperature_tenths; tuser[0] updated
//
// One byte per cycle is accepted; the CRC byte update is a single unrolled
// step between the state registers. A result is registered in the cycle after the
// closing byte and waits in the output register. Input is stalled only while
// that register holds a result that the downstream is not taking.
// Reset (rst_n, asynchronous) clears byte count and held readings; CRC set to FFFF.
// Top level of the sensor frame checker. Depends on sfc_pkg, sfc_frame, sfc_out_reg.
`timescale 1ns / 1ps

module sensor_frame_checker_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sfc_pkg::ByteW-1:0]           s_axis_tdata,  // [7:0] rx_byte
    input  logic                                s_axis_tuser,  // [0] frame_start
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] status, [17:2] humidity_raw, [33:18] temperature_raw,
    // [49:34] temperature_tenths, [55:50] zero
    output logic [sfc_pkg::ResultDataW-1:0]     m_axis_tdata,
    output logic                                m_axis_tuser   // [0] updated
);
    import sfc_pkg::*;

    logic    in_accept;
    logic    res_fire;
    logic    out_full;
    logic    out_take;
    result_t res_new;
    result_t res_out;

    assign out_take      = out_full && m_axis_tready;
    assign s_axis_tready = !out_full || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    sfc_frame u_frame
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .rx_byte     (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .result_fire (res_fire),
        .result      (res_new)
    );

    sfc_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_fire),
        .load_data (res_new),
        .take      (out_take),
        .full      (out_full),
        .data      (res_out)
    );

    assign m_axis_tvalid = out_full;
    assign m_axis_tdata  = {{(ResultDataW - ResultDataBits){1'b0}},
                            res_out.temperature_tenths,
                            res_out.temperature_raw,
                            res_out.humidity_raw,
                            res_out.status};
    assign m_axis_tuser  = res_out.updated;

`ifndef SYNTHESIS
    // A closing byte always leaves a result behind
    assert property (@(posedge clk) disable iff (!rst_n) res_fire |=> m_axis_tvalid)
        else $error("result lost after closing byte");

    // An update is only reported with a clean status
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[1:0] == STATUS_OK))
        else $error("update reported with failing status");

    // Positive temperatures pass through unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[33]) |-> (m_axis_tdata[49:34] == m_axis_tdata[33:18]))
        else $error("tenths decode mismatch");
`endif

endmodule

// ===== src/sfc_frame.sv =====
// Frame tracking: byte count, running CRC, captured fields and held readings.
// Depends on sfc_pkg. Produces one result per accepted closing byte.
`timescale 1ns / 1ps

module sfc_frame
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [sfc_pkg::ByteW-1:0] rx_byte,
    input  logic                     frame_start,
    output logic                     result_fire,
    output sfc_pkg::result_t         result
);
    import sfc_pkg::*;

    logic [IndexW-1:0] byte_index_reg,   byte_index_next;
    logic [WordW-1:0]  running_crc_reg,  running_crc_next;
    logic [ByteW-1:0]  command_byte_reg, command_byte_next;
    logic [ByteW-1:0]  length_byte_reg,  length_byte_next;
    logic [WordW-1:0]  frame_hum_reg,    frame_hum_next;
    logic [WordW-1:0]  frame_temp_reg,   frame_temp_next;
    logic [ByteW-1:0]  crc_low_reg,      crc_low_next;
    logic [WordW-1:0]  held_hum_reg,     held_hum_next;
    logic [WordW-1:0]  held_temp_reg,    held_temp_next;

    logic [IndexW-1:0] idx;
    logic [WordW-1:0]  crc_base;
    logic [WordW-1:0]  recv_crc;
    status_t           status;
    logic              pass;

    assign idx      = frame_start ? IDX_CMD : byte_index_reg;
    assign crc_base = (idx == IDX_CMD) ? CRC_START : running_crc_reg;
    assign recv_crc = {rx_byte, crc_low_reg};

    always_comb
    begin
        if (length_byte_reg != LEN_EXPECT)
            status = STATUS_BAD_LEN;
        else if (recv_crc != running_crc_reg)
            status = STATUS_BAD_CRC;
        else if (command_byte_reg != CMD_READ)
            status = STATUS_BAD_CMD;
        else
            status = STATUS_OK;
    end

    assign pass        = (status == STATUS_OK);
    assign result_fire = accept && (idx == IDX_CRC_HI);

    always_comb
    begin
        byte_index_next   = byte_index_reg;
        running_crc_next  = running_crc_reg;
        command_byte_next = command_byte_reg;
        length_byte_next  = length_byte_reg;
        frame_hum_next    = frame_hum_reg;
        frame_temp_next   = frame_temp_reg;
        crc_low_next      = crc_low_reg;
        held_hum_next     = held_hum_reg;
        held_temp_next    = held_temp_reg;
        if (accept)
        begin
            byte_index_next = idx + 1'b1;
            if (idx <= IDX_TEMP_LO)
                running_crc_next = crc_byte(crc_base, rx_byte);
            else
                running_crc_next = crc_base;
            case (idx)
                IDX_CMD:     command_byte_next = rx_byte;
                IDX_LEN:     length_byte_next  = rx_byte;
                IDX_HUM_HI:  frame_hum_next    = {rx_byte, frame_hum_reg[ByteW-1:0]};
                IDX_HUM_LO:  frame_hum_next    = {frame_hum_reg[WordW-1:ByteW], rx_byte};
                IDX_TEMP_HI: frame_temp_next   = {rx_byte, frame_temp_reg[ByteW-1:0]};
                IDX_TEMP_LO: frame_temp_next   = {frame_temp_reg[WordW-1:ByteW], rx_byte};
                IDX_CRC_LO:  crc_low_next      = rx_byte;
                default:
                begin
                    if (pass)
                    begin
                        held_hum_next  = frame_hum_reg;
                        held_temp_next = frame_temp_reg;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= '0;
            running_crc_reg  <= CRC_START;
            command_byte_reg <= '0;
            length_byte_reg  <= '0;
            frame_hum_reg    <= '0;
            frame_temp_reg   <= '0;
            crc_low_reg      <= '0;
            held_hum_reg     <= '0;
            held_temp_reg    <= '0;
        end
        else
        begin
            byte_index_reg   <= byte_index_next;
            running_crc_reg  <= running_crc_next;
            command_byte_reg <= command_byte_next;
            length_byte_reg  <= length_byte_next;
            frame_hum_reg    <= frame_hum_next;
            frame_temp_reg   <= frame_temp_next;
            crc_low_reg      <= crc_low_next;
            held_hum_reg     <= held_hum_next;
            held_temp_reg    <= held_temp_next;
        end
    end

    // Report the held values after any update by this frame
    assign result.status             = status;
    assign result.humidity_raw       = held_hum_next;
    assign result.temperature_raw    = held_temp_next;
    assign result.temperature_tenths = to_tenths(held_temp_next);
    assign result.updated            = pass;

endmodule

// ===== src/sfc_out_reg.sv =====
// Output register holding one finished result until the downstream takes it.
// Depends on sfc_pkg for the result type.
`timescale 1ns / 1ps

module sfc_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sfc_pkg::result_t load_data,
    input  logic             take,
    output logic             full,
    output sfc_pkg::result_t data
);
    import sfc_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg,  data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (take)
            valid_next = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = load_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload carries no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign full = valid_reg;
    assign data = data_reg;

endmodule
